// ===== sv/mwhw_pkg.sv =====
// ----------------------------------------------------------------------------
// mwhw_pkg
// Shared types and command codes for the multi-worker heartbeat watchdog.
// ----------------------------------------------------------------------------
package mwhw_pkg;

   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_KICK    = 3'd1;
   localparam logic [2:0] CMD_CLEAR   = 3'd2;
   localparam logic [2:0] CMD_HEALTH  = 3'd3;
   localparam logic [2:0] CMD_ENABLE  = 3'd4;
   localparam logic [2:0] CMD_DISABLE = 3'd5;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  slot;
      logic [15:0] grace;
      logic [15:0] fatal_grace;
      logic [15:0] inject_ticks;
   } req_type;

   typedef struct packed {
      logic healthy;
      logic slot_missed;
      logic fatal;
   } rsp_type;

endpackage

// ===== sv/multi_worker_heartbeat_watchdog_unit.sv =====
// ----------------------------------------------------------------------------
// multi_worker_heartbeat_watchdog_unit
// Bank of worker watchdogs sharing one saturating time counter, with
// kick/clear/enable/disable per slot and a health check walk over all slots.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  flow control
//  request   start, busy, req_data          in         start while !busy
//  response  rsp_valid, rsp_data            out        one-cycle strobe
//
//  A health check applies the saturating adder step for the inject window,
//  then reads one slot per cycle from the deadline RAMs.
//  Unknown commands and out-of-range slots go straight to the response.
//  Synchronous reset clears time, active/valid bits and the fatal flag.
//  busy stays high from acceptance until the response strobe cycle, in which
//  the next request can already be accepted.
//  The response cannot be stalled.
// ----------------------------------------------------------------------------
module multi_worker_heartbeat_watchdog_unit
   import mwhw_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = IDX_W + 4;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_TICK   = 11'b000_0000_0010,
      S_READ   = 11'b000_0000_0100,
      S_CHECK  = 11'b000_0000_1000,
      S_KSOFT  = 11'b000_0001_0000,
      S_KFATAL = 11'b000_0010_0000,
      S_INJECT = 11'b000_0100_0000,
      S_WALK   = 11'b000_1000_0000,
      S_DRAIN  = 11'b001_0000_0000,
      S_APPLY  = 11'b010_0000_0000,
      S_DONE   = 11'b100_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TIME_BITS-1:0] inject_until_ff, inject_until_in;
   logic                 fatal_seen_ff, fatal_seen_in;
   logic [SLOTS-1:0]     active_ff, active_in;
   logic [SLOTS-1:0]     entry_valid_ff, entry_valid_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic                 miss_acc_ff, miss_acc_in;
   logic                 smiss_ff, smiss_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // deadline RAMs, registered read
   logic [TIME_BITS-1:0] soft_mem  [SLOTS];
   logic [TIME_BITS-1:0] fatal_mem [SLOTS];
   logic [TIME_BITS-1:0] rd_soft_ff, rd_fatal_ff;
   logic                 rd_hit_ff, rd_act_ff;

   logic                 soft_we, fatal_we;
   logic [TIME_BITS-1:0] fatal_wdata;

   // shared saturating adder
   logic [15:0]          add_b;
   logic [TIME_BITS:0]   add_raw;
   logic [TIME_BITS-1:0] add_sum;

   logic                 accept;
   logic [CW-1:0]        slot_wide;
   logic                 slot_ok;
   logic                 soft_miss, fatal_miss;

   assign accept    = start && !busy;
   assign slot_wide = CW'(req_data.slot);
   assign slot_ok   = slot_wide < CW'(SLOTS);

   always_comb begin
      case (state_ff)
         S_TICK:   add_b = 16'd1;
         S_KSOFT:  add_b = req_ff.grace;
         S_KFATAL: add_b = req_ff.fatal_grace;
         S_INJECT: add_b = req_ff.inject_ticks;
         default:  add_b = 16'd0;
      endcase
   end

   assign add_raw = {1'b0, time_ff} + (TIME_BITS + 1)'(add_b);
   assign add_sum = add_raw[TIME_BITS] ? {TIME_BITS{1'b1}} : add_raw[TIME_BITS-1:0];

   // a zero deadline counts as disabled; an entry not yet kicked is masked by its valid bit
   assign soft_miss  = rd_hit_ff && (rd_soft_ff != '0) && (rd_soft_ff < time_ff);
   assign fatal_miss = rd_hit_ff && (rd_fatal_ff != '0) && (rd_fatal_ff < time_ff);

   assign fatal_wdata = (req_ff.fatal_grace != 16'd0) ? add_sum : '0;

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      time_in         = time_ff;
      inject_until_in = inject_until_ff;
      fatal_seen_in   = fatal_seen_ff;
      active_in       = active_ff;
      entry_valid_in  = entry_valid_ff;
      rd_idx_in       = rd_idx_ff;
      chk_vld_in      = 1'b0;
      miss_acc_in     = miss_acc_ff;
      smiss_in        = smiss_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      soft_we         = 1'b0;
      fatal_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               smiss_in  = 1'b0;
               rd_idx_in = slot_wide[IDX_W-1:0];
               case (req_data.cmd)
                  CMD_TICK:    state_in = S_TICK;
                  CMD_KICK:    state_in = slot_ok ? S_READ : S_DONE;
                  CMD_CLEAR:   state_in = slot_ok ? S_READ : S_DONE;
                  CMD_HEALTH:  state_in = S_INJECT;
                  CMD_ENABLE:  state_in = slot_ok ? S_APPLY : S_DONE;
                  CMD_DISABLE: state_in = slot_ok ? S_APPLY : S_DONE;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_TICK: begin
            time_in  = add_sum;
            state_in = S_DONE;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            smiss_in = soft_miss;
            if (fatal_miss) begin
               fatal_seen_in = 1'b1;
            end
            if (req_ff.cmd == CMD_KICK) begin
               state_in = S_KSOFT;
            end else begin
               entry_valid_in[rd_idx_ff] = 1'b0;
               state_in                  = S_DONE;
            end
         end
         S_KSOFT: begin
            soft_we  = 1'b1;
            state_in = S_KFATAL;
         end
         S_KFATAL: begin
            fatal_we                  = 1'b1;
            entry_valid_in[rd_idx_ff] = 1'b1;
            state_in                  = S_DONE;
         end
         S_INJECT: begin
            if (req_ff.inject_ticks != 16'd0) begin
               inject_until_in = add_sum;
            end
            rd_idx_in   = '0;
            miss_acc_in = 1'b0;
            state_in    = S_WALK;
         end
         S_WALK, S_DRAIN: begin
            // check stage sees the slot addressed in the previous cycle
            if (chk_vld_ff && rd_act_ff) begin
               if (fatal_miss) begin
                  fatal_seen_in = 1'b1;
               end
               if (soft_miss) begin
                  miss_acc_in = 1'b1;
               end
            end
            if (state_ff == S_WALK) begin
               chk_vld_in = 1'b1;
               if (rd_idx_ff == IDX_W'(SLOTS - 1)) begin
                  state_in = S_DRAIN;
               end else begin
                  rd_idx_in = IDX_W'(rd_idx_ff + 1'b1);
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_APPLY: begin
            if (req_ff.cmd == CMD_ENABLE) begin
               active_in[rd_idx_ff]      = 1'b1;
               entry_valid_in[rd_idx_ff] = 1'b0;
            end else begin
               active_in[rd_idx_ff] = 1'b0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.healthy     = (req_ff.cmd == CMD_HEALTH) && !miss_acc_ff &&
                                 !(time_ff < inject_until_ff);
            rsp_in.slot_missed = smiss_ff;
            rsp_in.fatal       = fatal_seen_ff;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         time_ff         <= '0;
         inject_until_ff <= '0;
         fatal_seen_ff   <= 1'b0;
         active_ff       <= '0;
         entry_valid_ff  <= '0;
         chk_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         time_ff         <= time_in;
         inject_until_ff <= inject_until_in;
         fatal_seen_ff   <= fatal_seen_in;
         active_ff       <= active_in;
         entry_valid_ff  <= entry_valid_in;
         chk_vld_ff      <= chk_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      miss_acc_ff <= miss_acc_in;
      smiss_ff    <= smiss_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (soft_we) begin
         soft_mem[rd_idx_ff] <= add_sum;
      end
      if (fatal_we) begin
         fatal_mem[rd_idx_ff] <= fatal_wdata;
      end
      rd_soft_ff  <= soft_mem[rd_idx_ff];
      rd_fatal_ff <= fatal_mem[rd_idx_ff];
      rd_hit_ff   <= entry_valid_ff[rd_idx_ff];
      rd_act_ff   <= active_ff[rd_idx_ff];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");

   a_fatal_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(fatal_seen_ff))
      else $error("fatal flag cleared outside reset");

   a_chk_walk: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == S_WALK || state_ff == S_DRAIN))
      else $error("slot check outside health walk");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses for one request");

endmodule
